// File: rtl/can_firmware_update_receiver_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the firmware update receiver
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef CAN_FIRMWARE_UPDATE_RECEIVER_TOP_MACROS_SVH
`define CAN_FIRMWARE_UPDATE_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define CFUR_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cfur assertion failed");

// next-cycle implication
`define CFUR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cfur assertion failed");

`endif

// File: rtl/cfur_pkg.sv
// ---------------------------------------------------------------------------
// cfur_pkg
// Types, codes and constants shared by the firmware update receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package cfur_pkg;

	localparam int PAGE_BYTES = 128;
	localparam int PAGE_BEATS = PAGE_BYTES / 8;
	localparam int BEAT_W     = $clog2(PAGE_BEATS);

	localparam logic [7:0]  CMD_BOOT       = 8'h40;
	localparam logic [15:0] HASH_BASE      = 16'h0301;
	localparam logic [7:0]  SUB_CHECK      = 8'h01;
	localparam logic [7:0]  SUB_PAGE_START = 8'h04;
	localparam logic [7:0]  SUB_PAGE_END   = 8'h05;
	localparam logic [7:0]  SUB_UPD_END    = 8'h07;
	localparam logic [63:0] FILL_WORD      = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic [31:0] RST_UID        = 32'd1128529920;
	localparam logic [15:0] RST_TIMEOUT    = 16'd400;
	localparam logic [7:0]  RST_PER_IDLE   = 8'd200;
	localparam logic [7:0]  RST_PER_UPD    = 8'd100;

	localparam logic [1:0]  REG_UID        = 2'd0;
	localparam logic [1:0]  REG_TIMEOUT    = 2'd1;
	localparam logic [1:0]  REG_PER_IDLE   = 2'd2;
	localparam logic [1:0]  REG_PER_UPD    = 2'd3;

	typedef enum logic [2:0] {
		K_REPLY  = 3'd0,
		K_BEAT   = 3'd1,
		K_SET    = 3'd2,
		K_CLEAR  = 3'd3,
		K_LAUNCH = 3'd4,
		K_LED    = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_TICK,
		ACT_ENTER,
		ACT_BOOTREQ,
		ACT_DATA,
		ACT_START,
		ACT_END_OK,
		ACT_END_FAIL,
		ACT_LEAVE,
		ACT_ABORT
	} act_t;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_LAUNCH,
		TAIL_LED
	} tail_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_CHECK,
		S_BEATS,
		S_REPLY,
		S_SINGLE,
		S_TAIL
	} state_t;

	typedef struct packed {
		logic [31:0] uid;
		logic [15:0] timeout;
		logic [7:0]  per_idle;
		logic [7:0]  per_upd;
	} cfg_t;

	typedef struct packed {
		logic              capture;
		logic              apply_frame;
		logic              apply_tail;
		logic              emit;
		kind_t             kind;
		logic              last;
		logic [BEAT_W-1:0] beat_idx;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic launch_hit;
		logic led_hit;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/cfur_regs.sv
// ---------------------------------------------------------------------------
// cfur_regs
// APB register bank: device id, boot timeout and LED periods.
// ---------------------------------------------------------------------------
`default_nettype none

module cfur_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic      [31:0]   prdata,
	output logic               pready,
	output cfur_pkg::cfg_t     cfg
);

	cfur_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uid      <= cfur_pkg::RST_UID;
			cfg_q.timeout  <= cfur_pkg::RST_TIMEOUT;
			cfg_q.per_idle <= cfur_pkg::RST_PER_IDLE;
			cfg_q.per_upd  <= cfur_pkg::RST_PER_UPD;
		end else if (wr_en) begin
			unique case (idx)
				cfur_pkg::REG_UID:      cfg_q.uid      <= pwdata;
				cfur_pkg::REG_TIMEOUT:  cfg_q.timeout  <= pwdata[15:0];
				cfur_pkg::REG_PER_IDLE: cfg_q.per_idle <= pwdata[7:0];
				cfur_pkg::REG_PER_UPD:  cfg_q.per_upd  <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cfur_pkg::REG_UID:      prdata = cfg_q.uid;
			cfur_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout};
			cfur_pkg::REG_PER_IDLE: prdata = {24'd0, cfg_q.per_idle};
			cfur_pkg::REG_PER_UPD:  prdata = {24'd0, cfg_q.per_upd};
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/cfur_datapath.sv
// ---------------------------------------------------------------------------
// cfur_datapath
// Frame decode, update state, page buffer, counters and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cfur_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfur_pkg::cfg_t    cfg,
	input  wire cfur_pkg::cmd_t    cmd,
	output cfur_pkg::status_t      status,
	input  wire logic [95:0]       s_tdata,
	input  wire logic [0:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [79:0]       m_tdata,
	output logic      [2:0]        m_tuser,
	output logic                   m_tlast
);

	// captured beat
	logic        op_q;
	logic [7:0]  cmd_q;
	logic        resp_q;
	logic [15:0] hash_q;
	logic [3:0]  dlc_q;
	logic [63:0] pl_q;

	// update state
	logic        updating_q;
	logic        launched_q;
	logic [7:0]  cur_page_q;
	logic [7:0]  beats_q;
	logic [15:0] ms_q;
	logic [7:0]  led_cnt_q;
	logic        led_state_q;
	logic [7:0]  pg_q;
	logic        ok_q;
	logic [63:0] store_q [cfur_pkg::PAGE_BEATS];

	// output register
	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic        out_last_q;
	logic [7:0]  out_page_q;
	logic        out_ok_q;
	logic [3:0]  out_beat_q;
	logic [63:0] out_data_q;
	logic        out_led_q;

	logic             addressed;
	logic [7:0]       b4, b5, b6;
	logic [15:0]      idx_w;
	logic             idx_ok;
	logic [7:0]       period;
	cfur_pkg::act_t   act;

	assign addressed = pl_q[63:32] == cfg.uid;
	assign b4        = pl_q[31:24];
	assign b5        = pl_q[23:16];
	assign b6        = pl_q[15:8];
	assign idx_w     = hash_q - cfur_pkg::HASH_BASE;
	assign idx_ok    = idx_w < 16'(cfur_pkg::PAGE_BEATS);
	assign period    = updating_q ? cfg.per_upd : cfg.per_idle;

	always_comb begin
		act = cfur_pkg::ACT_NONE;
		if (launched_q) begin
			act = cfur_pkg::ACT_NONE;
		end else if (op_q) begin
			act = cfur_pkg::ACT_TICK;
		end else if (cmd_q == cfur_pkg::CMD_BOOT) begin
			if (!updating_q) begin
				if (addressed) begin
					if (dlc_q == 4'd7 && resp_q && b4 == cfur_pkg::SUB_CHECK) begin
						if (b6 == 8'd1)
							act = cfur_pkg::ACT_ENTER;
					end else if (dlc_q == 4'd4) begin
						act = cfur_pkg::ACT_BOOTREQ;
					end
				end
			end else if (dlc_q == 4'd8) begin
				act = cfur_pkg::ACT_DATA;
			end else if (addressed) begin
				case (b4)
					cfur_pkg::SUB_PAGE_START: act = cfur_pkg::ACT_START;
					cfur_pkg::SUB_PAGE_END: begin
						if (cur_page_q == b5 && beats_q == 8'(cfur_pkg::PAGE_BEATS))
							act = cfur_pkg::ACT_END_OK;
						else
							act = cfur_pkg::ACT_END_FAIL;
					end
					cfur_pkg::SUB_UPD_END:    act = cfur_pkg::ACT_LEAVE;
					default:                  act = cfur_pkg::ACT_ABORT;
				endcase
			end
		end
	end

	assign status.act        = act;
	assign status.launch_hit = !launched_q && ms_q >= cfg.timeout && !updating_q;
	assign status.led_hit    = !launched_q && !status.launch_hit && op_q && led_cnt_q >= period;
	assign status.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= s_tuser[0];
			cmd_q  <= s_tdata[7:0];
			resp_q <= s_tdata[8];
			hash_q <= s_tdata[24:9];
			dlc_q  <= s_tdata[28:25];
			pl_q   <= s_tdata[92:29];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			updating_q  <= 1'b0;
			launched_q  <= 1'b0;
			cur_page_q  <= 8'd0;
			beats_q     <= 8'd0;
			ms_q        <= 16'd0;
			led_cnt_q   <= 8'd0;
			led_state_q <= 1'b1;
			pg_q        <= 8'd0;
			ok_q        <= 1'b0;
		end else if (cmd.apply_frame) begin
			case (act)
				cfur_pkg::ACT_TICK: begin
					if (ms_q != 16'hFFFF)
						ms_q <= ms_q + 16'd1;
					if (led_cnt_q != 8'hFF)
						led_cnt_q <= led_cnt_q + 8'd1;
				end
				cfur_pkg::ACT_ENTER: updating_q <= 1'b1;
				cfur_pkg::ACT_DATA:  beats_q <= beats_q + 8'd1;
				cfur_pkg::ACT_START: cur_page_q <= b5;
				cfur_pkg::ACT_END_OK: begin
					pg_q    <= b5;
					ok_q    <= 1'b1;
					beats_q <= 8'd0;
				end
				cfur_pkg::ACT_END_FAIL: begin
					pg_q    <= b5;
					ok_q    <= 1'b0;
					beats_q <= 8'd0;
				end
				cfur_pkg::ACT_LEAVE: updating_q <= 1'b0;
				cfur_pkg::ACT_ABORT: begin
					updating_q <= 1'b0;
					pg_q       <= 8'd0;
				end
				default: ;
			endcase
		end else if (cmd.apply_tail) begin
			if (status.launch_hit) begin
				launched_q <= 1'b1;
			end else if (status.led_hit) begin
				led_cnt_q   <= 8'd0;
				led_state_q <= !led_state_q;
			end
		end
	end

	// page buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cfur_pkg::PAGE_BEATS; i++)
				store_q[i] <= 64'd0;
		end else if (cmd.apply_frame) begin
			if (act == cfur_pkg::ACT_DATA && idx_ok) begin
				store_q[idx_w[cfur_pkg::BEAT_W-1:0]] <= pl_q;
			end else if (act == cfur_pkg::ACT_ABORT) begin
				for (int i = 0; i < cfur_pkg::PAGE_BEATS; i++)
					store_q[i] <= cfur_pkg::FILL_WORD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			out_last_q <= cmd.last;
			out_page_q <= 8'd0;
			out_ok_q   <= 1'b0;
			out_beat_q <= 4'd0;
			out_data_q <= 64'd0;
			out_led_q  <= 1'b0;
			case (cmd.kind)
				cfur_pkg::K_REPLY: begin
					out_page_q <= pg_q;
					out_ok_q   <= ok_q;
				end
				cfur_pkg::K_BEAT: begin
					out_page_q <= pg_q;
					out_beat_q <= 4'(cmd.beat_idx);
					out_data_q <= store_q[cmd.beat_idx];
				end
				cfur_pkg::K_LED: out_led_q <= led_state_q;
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'd0, out_led_q, out_data_q, out_beat_q, out_ok_q, out_page_q};

endmodule

`default_nettype wire

// File: rtl/cfur_ctrl.sv
// ---------------------------------------------------------------------------
// cfur_ctrl
// Sequencer: capture, evaluate, tail check, then result emission.
// ---------------------------------------------------------------------------
`default_nettype none

`include "can_firmware_update_receiver_top_macros.svh"

module cfur_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire cfur_pkg::status_t status,
	output cfur_pkg::cmd_t     cmd
);

	cfur_pkg::state_t            state_q, state_d;
	cfur_pkg::act_t              act_q;
	cfur_pkg::tail_t             tail_q, tail_d;
	logic [cfur_pkg::BEAT_W-1:0] beat_q;
	logic                        beat_end;
	cfur_pkg::state_t            after_frame;

	assign beat_end    = beat_q == cfur_pkg::BEAT_W'(cfur_pkg::PAGE_BEATS - 1);
	assign after_frame = (tail_q != cfur_pkg::TAIL_NONE) ? cfur_pkg::S_TAIL : cfur_pkg::S_IDLE;

	always_comb begin
		if (status.launch_hit)
			tail_d = cfur_pkg::TAIL_LAUNCH;
		else if (status.led_hit)
			tail_d = cfur_pkg::TAIL_LED;
		else
			tail_d = cfur_pkg::TAIL_NONE;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfur_pkg::S_IDLE:  if (s_tvalid) state_d = cfur_pkg::S_EVAL;
			cfur_pkg::S_EVAL:  state_d = cfur_pkg::S_CHECK;
			cfur_pkg::S_CHECK: begin
				case (act_q)
					cfur_pkg::ACT_END_OK,
					cfur_pkg::ACT_ABORT:    state_d = cfur_pkg::S_BEATS;
					cfur_pkg::ACT_END_FAIL: state_d = cfur_pkg::S_REPLY;
					cfur_pkg::ACT_ENTER,
					cfur_pkg::ACT_BOOTREQ:  state_d = cfur_pkg::S_SINGLE;
					default: state_d = (tail_d != cfur_pkg::TAIL_NONE) ?
						cfur_pkg::S_TAIL : cfur_pkg::S_IDLE;
				endcase
			end
			cfur_pkg::S_BEATS: begin
				if (status.out_free && beat_end)
					state_d = (act_q == cfur_pkg::ACT_END_OK) ? cfur_pkg::S_REPLY : after_frame;
			end
			cfur_pkg::S_REPLY,
			cfur_pkg::S_SINGLE: if (status.out_free) state_d = after_frame;
			cfur_pkg::S_TAIL:   if (status.out_free) state_d = cfur_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = 1'b0;
		cmd.capture     = 1'b0;
		cmd.apply_frame = 1'b0;
		cmd.apply_tail  = 1'b0;
		cmd.emit        = 1'b0;
		cmd.kind        = cfur_pkg::K_REPLY;
		cmd.last        = 1'b0;
		cmd.beat_idx    = beat_q;
		unique case (state_q)
			cfur_pkg::S_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			cfur_pkg::S_EVAL:  cmd.apply_frame = 1'b1;
			cfur_pkg::S_CHECK: cmd.apply_tail  = 1'b1;
			cfur_pkg::S_BEATS: begin
				cmd.emit = status.out_free;
				cmd.kind = cfur_pkg::K_BEAT;
				cmd.last = beat_end && act_q == cfur_pkg::ACT_ABORT &&
					tail_q == cfur_pkg::TAIL_NONE;
			end
			cfur_pkg::S_REPLY: begin
				cmd.emit = status.out_free;
				cmd.kind = cfur_pkg::K_REPLY;
				cmd.last = tail_q == cfur_pkg::TAIL_NONE;
			end
			cfur_pkg::S_SINGLE: begin
				cmd.emit = status.out_free;
				cmd.kind = (act_q == cfur_pkg::ACT_ENTER) ? cfur_pkg::K_CLEAR : cfur_pkg::K_SET;
				cmd.last = tail_q == cfur_pkg::TAIL_NONE;
			end
			cfur_pkg::S_TAIL: begin
				cmd.emit = status.out_free;
				cmd.kind = (tail_q == cfur_pkg::TAIL_LAUNCH) ? cfur_pkg::K_LAUNCH : cfur_pkg::K_LED;
				cmd.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfur_pkg::S_IDLE;
			act_q   <= cfur_pkg::ACT_NONE;
			tail_q  <= cfur_pkg::TAIL_NONE;
			beat_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cfur_pkg::S_EVAL)
				act_q <= status.act;
			if (state_q == cfur_pkg::S_CHECK) begin
				tail_q <= tail_d;
				beat_q <= '0;
			end else if (state_q == cfur_pkg::S_BEATS && status.out_free) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	`CFUR_ASSERT(a_emit_free, clk, arst_n, cmd.emit, status.out_free)
	`CFUR_ASSERT_NEXT(a_accept_eval, clk, arst_n, s_tvalid && s_tready, state_q == cfur_pkg::S_EVAL)
	`CFUR_ASSERT(a_beats_act, clk, arst_n, state_q == cfur_pkg::S_BEATS, act_q == cfur_pkg::ACT_END_OK || act_q == cfur_pkg::ACT_ABORT)
	`CFUR_ASSERT(a_beat_last, clk, arst_n, cmd.emit && cmd.last && cmd.kind == cfur_pkg::K_BEAT, beat_end)

endmodule

`default_nettype wire

// File: rtl/can_firmware_update_receiver_top.sv
// ---------------------------------------------------------------------------
// can_firmware_update_receiver_top
// Bootloader receiver: CAN frames and ms ticks in, flash and control events out.
// ---------------------------------------------------------------------------
//  channel   dir   handshake            contents
//  s_*       in    s_tvalid/s_tready    one frame or tick per beat
//  m_*       out   m_tvalid/m_tready    one event per beat, m_tlast on the final one
//  apb       in    psel/penable/pready  four config registers at 0x0..0xC
//
//  An input passes through capture, evaluate and tail check, then one result beat
//  is emitted per cycle while m_tready does not stall it; a page write is 17 results.
//  Reset clears update state, counters and page buffer at once; no clearing pass.
//  A stalled m_tready holds the sequencer; the next input is taken once the
//  last result sits in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module can_firmware_update_receiver_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// command[7:0], response_bit[8], frame_hash[24:9], length_code[28:25], payload[92:29]
	input  wire logic [95:0] s_tdata,
	// operation[0]
	input  wire logic [0:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// page_number[7:0], page_ok[8], beat_index[12:9], flash_data[76:13], led_level[77]
	output logic      [79:0] m_tdata,
	// kind[2:0]
	output logic      [2:0]  m_tuser,
	output logic             m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	cfur_pkg::cfg_t    cfg;
	cfur_pkg::cmd_t    cmd;
	cfur_pkg::status_t status;

	cfur_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cfur_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	cfur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

endmodule

`default_nettype wire

// File: tb/can_firmware_update_receiver_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// can_firmware_update_receiver_top_test
// Self-checking bench for the firmware update receiver. A short table of
// directed beats covers the decode corners and the reset settings. Random
// traffic follows, mostly well-formed update sessions (enter, page start,
// sixteen data beats, page end) with broken pages, aborts, ticks and noise
// mixed in. Every accepted input is run through a local model of the
// receiver, and each output beat is compared field by field with the
// oldest predicted event. Settings change between phases over APB, with
// read-back. The run ends with the launch and checks that the block then
// stays silent.
// ---------------------------------------------------------------------------

module can_firmware_update_receiver_top_test;

	import cfur_pkg::*;

	localparam logic OP_FRAME      = 1'b0;
	localparam logic OP_TICK       = 1'b1;
	localparam int   HOLD_CYCLES   = 300;
	localparam int   SETTLE_CYCLES = 40;
	localparam int   CYCLE_LIMIT   = 500000;

	typedef struct {
		logic        op;
		logic [7:0]  cmd;
		logic        resp;
		logic [15:0] hash;
		logic [3:0]  dlc;
		logic [63:0] pl;
	} frame_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  page;
		logic        ok;
		logic [3:0]  beat;
		logic [63:0] data;
		logic        led;
		logic        last;
	} result_t;

	typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_t;

	typedef struct {
		frame_t     f;
		row_chk_t   chk;
		kind_t      kind;
		logic [7:0] page;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	can_firmware_update_receiver_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// register mirror
	logic [31:0] cfg_uid = RST_UID;
	logic [15:0] cfg_timeout = RST_TIMEOUT;
	logic [7:0]  cfg_per_idle = RST_PER_IDLE;
	logic [7:0]  cfg_per_upd = RST_PER_UPD;

	// receiver model state
	logic        mdl_updating = 1'b0;
	logic        mdl_launched = 1'b0;
	logic [7:0]  mdl_page_no = '0;
	logic [7:0]  mdl_beats = '0;
	logic [63:0] mdl_page_buf [PAGE_BEATS];
	logic [15:0] mdl_ms = '0;
	logic [7:0]  mdl_led_count = '0;
	logic        mdl_led = 1'b1;

	result_t  step_results[$];
	result_t  pending_events[$];
	dir_row_t dir_rows[$];

	int send_idle_pct = 29;
	int recv_idle_pct = 87;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int n_frames = 0;
	int n_ticks = 0;
	int n_checked = 0;
	int n_pages_ok = 0;
	int n_pages_bad = 0;
	int n_led = 0;

	function automatic logic [7:0] r8();
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [15:0] r16();
		return 16'($urandom_range(65535));
	endfunction

	function automatic logic [63:0] r64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pl_byte(logic [63:0] p, int i);
		return p[63 - 8 * i -: 8];
	endfunction

	function automatic frame_t mk_frame(logic op, logic [7:0] cmd, logic resp,
			logic [15:0] hash, logic [3:0] dlc, logic [63:0] pl);
		frame_t f;
		f.op = op;
		f.cmd = cmd;
		f.resp = resp;
		f.hash = hash;
		f.dlc = dlc;
		f.pl = pl;
		return f;
	endfunction

	function automatic result_t mk_result(kind_t k, logic [7:0] pg, logic ok,
			logic [3:0] b, logic [63:0] d, logic led);
		result_t r;
		r.kind = k;
		r.page = pg;
		r.ok = ok;
		r.beat = b;
		r.data = d;
		r.led = led;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic logic [63:0] pl_ctl(logic [31:0] uid, logic [7:0] b4, logic [7:0] b5,
			logic [7:0] b6);
		return {uid, b4, b5, b6, 8'h5A};
	endfunction

	function automatic dir_row_t dir_row(frame_t f, row_chk_t c, kind_t k, logic [7:0] pg);
		dir_row_t r;
		r.f = f;
		r.chk = c;
		r.kind = k;
		r.page = pg;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch @%0d: %s", cycles, msg);
	endtask

	task automatic model_write_page(input logic [7:0] pg);
		for (int b = 0; b < PAGE_BEATS; b++)
			step_results.push_back(mk_result(K_BEAT, pg, 1'b0, 4'(b), mdl_page_buf[b], 1'b0));
	endtask

	task automatic receiver_model_step(input frame_t f);
		logic        addressed;
		logic [15:0] idx;
		logic [7:0]  sub;
		logic [7:0]  pg;
		logic [7:0]  period;
		step_results.delete();
		if (mdl_launched)
			return;
		addressed = (f.pl[63:32] == cfg_uid);
		if (f.op == OP_TICK) begin
			if (mdl_ms != 16'hFFFF)
				mdl_ms++;
			if (mdl_led_count != 8'hFF)
				mdl_led_count++;
		end else if (f.cmd == CMD_BOOT) begin
			if (!mdl_updating) begin
				if (addressed) begin
					if (f.dlc == 4'd7 && f.resp && pl_byte(f.pl, 4) == SUB_CHECK) begin
						if (pl_byte(f.pl, 6) == 8'h01) begin
							mdl_updating = 1'b1;
							step_results.push_back(mk_result(K_CLEAR, '0, 1'b0, '0, '0, 1'b0));
						end
					end else if (f.dlc == 4'd4) begin
						step_results.push_back(mk_result(K_SET, '0, 1'b0, '0, '0, 1'b0));
					end
				end
			end else if (f.dlc == 4'd8) begin
				idx = f.hash - HASH_BASE;
				mdl_beats++;
				if (idx < PAGE_BEATS)
					mdl_page_buf[idx] = f.pl;
			end else if (addressed) begin
				sub = pl_byte(f.pl, 4);
				pg = pl_byte(f.pl, 5);
				if (sub == SUB_PAGE_START) begin
					mdl_page_no = pg;
				end else if (sub == SUB_PAGE_END) begin
					if (mdl_page_no == pg && mdl_beats == PAGE_BEATS) begin
						model_write_page(pg);
						step_results.push_back(mk_result(K_REPLY, pg, 1'b1, '0, '0, 1'b0));
						n_pages_ok++;
					end else begin
						step_results.push_back(mk_result(K_REPLY, pg, 1'b0, '0, '0, 1'b0));
						n_pages_bad++;
					end
					mdl_beats = '0;
				end else if (sub == SUB_UPD_END) begin
					mdl_updating = 1'b0;
				end else begin
					foreach (mdl_page_buf[b])
						mdl_page_buf[b] = FILL_WORD;
					model_write_page('0);
					mdl_updating = 1'b0;
				end
			end
		end
		if (mdl_ms >= cfg_timeout && !mdl_updating) begin
			mdl_launched = 1'b1;
			step_results.push_back(mk_result(K_LAUNCH, '0, 1'b0, '0, '0, 1'b0));
		end else if (f.op == OP_TICK) begin
			period = mdl_updating ? cfg_per_upd : cfg_per_idle;
			if (mdl_led_count >= period) begin
				mdl_led_count = '0;
				mdl_led = ~mdl_led;
				step_results.push_back(mk_result(K_LED, '0, 1'b0, '0, '0, mdl_led));
				n_led++;
			end
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endtask

	// offer one beat, run the model on acceptance; results left in step_results
	task automatic send_frame(input frame_t f);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, f.pl, f.dlc, f.hash, f.resp, f.cmd};
		s_tuser <= f.op;
		do @(posedge clk); while (!s_tready);
		receiver_model_step(f);
		if (f.op == OP_TICK)
			n_ticks++;
		else
			n_frames++;
	endtask

	task automatic offer(input frame_t f);
		send_frame(f);
		foreach (step_results[i])
			pending_events.push_back(step_results[i]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_UID:      cfg_uid = value;
			REG_TIMEOUT:  cfg_timeout = value[15:0];
			REG_PER_IDLE: cfg_per_idle = value[7:0];
			REG_PER_UPD:  cfg_per_upd = value[7:0];
			default: ;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== value)
			report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, rd, value));
	endtask

	task automatic apply_settings(input logic [31:0] uid, input logic [15:0] tmo,
			input logic [7:0] per_idle, input logic [7:0] per_upd);
		cfg_write(REG_UID, uid);
		cfg_write(REG_TIMEOUT, {16'h0, tmo});
		cfg_write(REG_PER_IDLE, {24'h0, per_idle});
		cfg_write(REG_PER_UPD, {24'h0, per_upd});
	endtask

	function automatic frame_t ctl_frame(logic [7:0] sub, logic [7:0] pg);
		return mk_frame(OP_FRAME, CMD_BOOT, 1'($urandom_range(1)), r16(),
			4'($urandom_range(7)), {cfg_uid, sub, pg, r8(), r8()});
	endfunction

	function automatic frame_t tick_frame();
		return mk_frame(OP_TICK, r8(), 1'($urandom_range(1)), r16(),
			4'($urandom_range(8)), r64());
	endfunction

	function automatic frame_t noise_frame();
		return mk_frame(OP_FRAME, ($urandom_range(3) == 0) ? CMD_BOOT : r8(),
			1'($urandom_range(1)), r16(), 4'($urandom_range(8)), r64());
	endfunction

	function automatic frame_t enter_frame();
		return mk_frame(OP_FRAME, CMD_BOOT, 1'b1, r16(), 4'd7,
			{cfg_uid, SUB_CHECK, r8(), 8'h01, r8()});
	endfunction

	// a page: start, sixteen data beats in random order, end; at times flawed
	task automatic page_run();
		int         order[PAGE_BEATS];
		int         j;
		int         tmp;
		int         flaw;
		logic [7:0] pg;
		logic [15:0] hash;
		pg = r8();
		flaw = $urandom_range(9);
		for (int i = 0; i < PAGE_BEATS; i++)
			order[i] = i;
		for (int i = PAGE_BEATS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		offer(ctl_frame(SUB_PAGE_START, pg));
		for (int i = 0; i < PAGE_BEATS; i++) begin
			if (!(flaw == 0 && i == PAGE_BEATS - 1)) begin
				if ($urandom_range(9) == 0)
					offer(tick_frame());
				hash = HASH_BASE + 16'(order[i]);
				if (flaw == 2 && i == 7)
					hash = HASH_BASE + 16'(PAGE_BEATS) + 16'($urandom_range(60000));
				offer(mk_frame(OP_FRAME, CMD_BOOT, 1'($urandom_range(1)), hash, 4'd8, r64()));
			end
		end
		if (flaw == 1)
			offer(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, HASH_BASE + 16'(order[0]), 4'd8, r64()));
		if ($urandom_range(9) == 0)
			pg = pg ^ (r8() | 8'h01);
		offer(ctl_frame(SUB_PAGE_END, pg));
	endtask

	task automatic update_step();
		int         w;
		logic [7:0] sub;
		frame_t     f;
		w = $urandom_range(99);
		if (w < 55) begin
			page_run();
		end else if (w < 65) begin
			repeat ($urandom_range(4, 1)) offer(tick_frame());
		end else if (w < 75) begin
			offer(noise_frame());
		end else if (w < 83) begin
			do sub = r8();
			while (sub == SUB_PAGE_START || sub == SUB_PAGE_END || sub == SUB_UPD_END);
			offer(ctl_frame(sub, r8()));
		end else if (w < 91) begin
			offer(ctl_frame(SUB_UPD_END, r8()));
		end else begin
			f = ctl_frame(SUB_PAGE_END, r8());
			if ($urandom_range(1))
				f.pl[63:32] = ~cfg_uid;
			offer(f);
		end
	endtask

	task automatic idle_step();
		int     w;
		frame_t f;
		w = $urandom_range(99);
		if (w < 45) begin
			offer(enter_frame());
		end else if (w < 60) begin
			offer(mk_frame(OP_FRAME, CMD_BOOT, 1'($urandom_range(1)), r16(), 4'd4,
				{cfg_uid, $urandom}));
		end else if (w < 80) begin
			f = enter_frame();
			case ($urandom_range(5))
				0: f.resp = 1'b0;
				1: f.dlc = 4'($urandom_range(6));
				2: f.pl[31:24] = SUB_CHECK ^ 8'($urandom_range(255, 1));
				3: f.pl[15:8] = 8'h01 ^ 8'($urandom_range(255, 1));
				4: f.pl[63:32] = cfg_uid ^ $urandom_range(32'hFFFF, 1);
				default: f.cmd = CMD_BOOT ^ 8'($urandom_range(255, 1));
			endcase
			offer(f);
		end else if (w < 90) begin
			offer(tick_frame());
		end else begin
			offer(noise_frame());
		end
	endtask

	task automatic random_burst(input int count);
		int target;
		target = n_frames + n_ticks + count;
		while (n_frames + n_ticks < target) begin
			if (mdl_updating)
				update_step();
			else
				idle_step();
		end
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got = mk_result(kind_t'(m_tuser), m_tdata[7:0], m_tdata[8], m_tdata[12:9],
			m_tdata[76:13], m_tdata[77]);
		got.last = m_tlast;
		if (pending_events.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, kind %0d", m_tuser));
			return;
		end
		want = pending_events.pop_front();
		n_checked++;
		if (got.kind !== want.kind || got.page !== want.page || got.ok !== want.ok ||
				got.beat !== want.beat || got.data !== want.data || got.led !== want.led ||
				got.last !== want.last)
			report_mismatch($sformatf(
				"kind %0d/%0d page %h/%h ok %b/%b beat %0d/%0d data %h/%h led %b/%b last %b/%b",
				got.kind, want.kind, got.page, want.page, got.ok, want.ok, got.beat, want.beat,
				got.data, want.data, got.led, want.led, got.last, want.last));
	endtask

	// output side: check, back-pressure, long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout with %0d events outstanding", pending_events.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int     k;
		frame_t tick_ones;
		foreach (mdl_page_buf[i])
			mdl_page_buf[i] = '0;

		tick_ones = mk_frame(OP_TICK, 8'hFF, 1'b1, 16'hFFFF, 4'd8, '1);
		dir_rows.push_back(dir_row(tick_ones, CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, ~CMD_BOOT, 1'b1, '0, 4'd4,
			{RST_UID, 32'h0}), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd4,
			{RST_UID ^ 32'h1, 32'h0}), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd4,
			{RST_UID, 32'h0}), CHK_ONE, K_SET, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, '0, 4'd7,
			pl_ctl(RST_UID, SUB_CHECK, '0, 8'h00)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd7,
			pl_ctl(RST_UID, SUB_CHECK, '0, 8'h01)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, '0, 4'd8,
			pl_ctl(RST_UID, SUB_CHECK, '0, 8'h01)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, 16'hFFFF, 4'd7,
			pl_ctl(RST_UID, SUB_CHECK, '0, 8'h01)), CHK_ONE, K_CLEAR, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd6,
			pl_ctl(RST_UID, SUB_PAGE_START, 8'hFF, '0)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, HASH_BASE - 16'd1, 4'd8,
			64'h0123_4567_89AB_CDEF), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, 16'hFFFF, 4'd8, '1),
			CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd5,
			pl_ctl(RST_UID, SUB_PAGE_END, 8'hFF, '0)), CHK_ONE, K_REPLY, 8'hFF));
		dir_rows.push_back(dir_row(tick_ones, CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, HASH_BASE, 4'd8, '0),
			CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0,
			HASH_BASE + 16'(PAGE_BEATS - 1), 4'd8, '1), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0,
			HASH_BASE + 16'(PAGE_BEATS), 4'd8, '1), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd7,
			pl_ctl(~RST_UID, SUB_PAGE_END, '0, '0)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, 8'h00, 1'b0, HASH_BASE, 4'd8, '1),
			CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd0,
			pl_ctl(RST_UID, SUB_PAGE_START, '0, '0)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, '0, 4'd3,
			pl_ctl(RST_UID, SUB_PAGE_END, '0, '0)), CHK_ONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd7,
			pl_ctl(RST_UID, SUB_CHECK, '0, '0)), CHK_MODEL, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, '0, 4'd7,
			pl_ctl(RST_UID, SUB_CHECK, '0, 8'h01)), CHK_ONE, K_CLEAR, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b0, '0, 4'd2,
			pl_ctl(RST_UID, SUB_UPD_END, '0, '0)), CHK_NONE, K_REPLY, '0));
		dir_rows.push_back(dir_row(mk_frame(OP_FRAME, CMD_BOOT, 1'b1, '0, 4'd4,
			pl_ctl(RST_UID, SUB_CHECK, '0, '0)), CHK_ONE, K_SET, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// directed table, reset settings
		foreach (dir_rows[i]) begin
			send_frame(dir_rows[i].f);
			case (dir_rows[i].chk)
				CHK_MODEL: foreach (step_results[n]) pending_events.push_back(step_results[n]);
				CHK_ONE: begin
					pending_events.push_back(mk_result(dir_rows[i].kind, dir_rows[i].page,
						1'b0, '0, '0, 1'b0));
					pending_events[pending_events.size() - 1].last = 1'b1;
				end
				default: ;
			endcase
		end
		drain();

		// sender sparse idling, receiver heavy
		apply_settings($urandom, 16'hFFFF, 8'd1, 8'd255);
		random_burst(170);
		drain();

		// the other way round, with a long output hold-off
		send_idle_pct = 87;
		recv_idle_pct = 29;
		apply_settings(32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd1);
		random_burst(30);
		hold_req = 1'b1;
		random_burst(140);
		drain();

		// no idling; sender pauses for a full drain mid-phase
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(32'h0, 16'hFFFF, 8'($urandom_range(6, 1)), 8'($urandom_range(6, 1)));
		random_burst(80);
		drain();
		random_burst(80);
		drain();

		// launch: zero timeout armed while updating, fires on leaving update mode
		send_idle_pct = 29;
		recv_idle_pct = 29;
		if (!mdl_updating)
			offer(enter_frame());
		drain();
		apply_settings($urandom, 16'h0, 8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
		k = 0;
		while (!mdl_launched && k < 8) begin
			update_step();
			k++;
		end
		if (!mdl_launched)
			offer(ctl_frame(SUB_UPD_END, r8()));
		repeat (10) idle_step();
		drain();

		$display("%0d frames and %0d ticks in, %0d result beats checked",
			n_frames, n_ticks, n_checked);
		$display("%0d pages written, %0d resend replies, %0d LED toggles, launch %0s",
			n_pages_ok, n_pages_bad, n_led, mdl_launched ? "seen" : "missing");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
